/* rtl/bclru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bclru_pkg
// Types and constants shared by the cache tag and policy engine.
// ----------------------------------------------------------------------------
package bclru_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int SCAN_BITS  = SLOT_BITS + 1;
   localparam logic [15:0] DEFAULT_BLOCK_BYTES = 16'd1024;

   typedef enum logic [2:0] {
      CMD_READ      = 3'd0,
      CMD_WRITE     = 3'd1,
      CMD_PARTIAL   = 3'd2,
      CMD_FLUSH     = 3'd3,
      CMD_INVALIDATE = 3'd4,
      CMD_DIRTY_LIST = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_FILL      = 3'd0,
      KIND_WRITEBACK = 3'd1,
      KIND_DONE      = 3'd2,
      KIND_REPORT    = 3'd3,
      KIND_REJECT    = 3'd4
   } kind_type;

   typedef enum logic [0:0] {
      CSR_BASE_LBA    = 1'b0,
      CSR_BLOCK_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_WB,
      ST_FILL,
      ST_DONE,
      ST_SWEEP,
      ST_SWEEP_OUT,
      ST_WIPE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic [31:0] blk;
      logic [31:0] stamp;
   } slot_type;

   typedef struct packed {
      logic                 strobe;
      kind_type             kind;
      logic [SLOT_BITS-1:0] slot;
      logic [31:0]          blk;
      logic                 lba_en;
      logic [15:0]          clip;
      logic [4:0]           count;
      logic                 last;
   } rsp_ctl_type;

endpackage
`default_nettype wire

/* rtl/block_cache_lru_controller_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// block_cache_lru_controller_core
// Tag and LRU policy engine of a fully associative write-back block cache.
//
//   Channel  Ports                   Handshake
//   request  req_*  , start, busy    accepted when start and not busy
//   result   rsp_*  , rsp_strobe     one-cycle strobe per result, no stall
//   config   csr_*                   written when csr_write is high
//
// Slot state lives in one synchronous memory, read one slot per cycle.
// A read, write or partial command scans the slots in order until a hit or the
// last slot, then fills the victim on a miss, writing a dirty victim back first.
// Flush, invalidate and dirty list sweep every slot; a rejected command goes
// straight to the done state. Each result is registered and leaves in the cycle
// after the state that makes it. After reset a clearing pass zeroes every slot
// with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module block_cache_lru_controller_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_block_number,
   input  wire logic [15:0] req_byte_offset,
   input  wire logic [15:0] req_byte_length,
   input  wire logic [4:0]  req_max_reports,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_kind,
   output logic [3:0]       rsp_slot_index,
   output logic [31:0]      rsp_result_block,
   output logic [31:0]      rsp_device_lba,
   output logic [7:0]       rsp_sector_count,
   output logic [15:0]      rsp_clipped_length,
   output logic [4:0]       rsp_report_count,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int SB = bclru_pkg::SLOT_BITS;
   localparam int CB = bclru_pkg::SCAN_BITS;

   bclru_pkg::slot_type mem [bclru_pkg::NUM_SLOTS];
   bclru_pkg::slot_type rd_ff;
   logic                we;
   logic [SB-1:0]       waddr;
   bclru_pkg::slot_type wdata;
   logic [SB-1:0]       raddr;

   bclru_pkg::state_type state_ff, state_in;
   logic [CB-1:0]   cnt_ff, cnt_in;
   logic [SB-1:0]   rslot_ff;
   logic            rvalid_ff, rvalid_in;
   bclru_pkg::cmd_type cmd_ff;
   logic [31:0]     blk_ff;
   logic [15:0]     clip_ff;
   logic [4:0]      maxr_ff;
   logic [4:0]      rep_ff, rep_in;
   logic            hit_ff, hit_in;
   logic            inv_ff, inv_in;
   logic [SB-1:0]   vic_ff, vic_in;
   logic [31:0]     vstamp_ff, vstamp_in;
   bclru_pkg::slot_type vslot_ff, vslot_in;
   logic [31:0]     clock_ff;
   logic [31:0]     base_ff;
   logic [15:0]     bytes_ff;
   logic            reject_ff;

   bclru_pkg::rsp_ctl_type ctl_in, ctl_ff;

   logic [15:0] eff_bytes;
   logic [7:0]  sectors;
   logic [16:0] off_len;
   logic        scan_end;
   logic [31:0] lba_blk;
   logic [31:0] rsp_device_lba_raw;

   assign eff_bytes = (bytes_ff == 16'd0) ? bclru_pkg::DEFAULT_BLOCK_BYTES : bytes_ff;
   assign sectors   = {1'b0, eff_bytes[15:9]};
   assign scan_end  = (cnt_ff == CB'(bclru_pkg::NUM_SLOTS));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bytes_ff <= bclru_pkg::DEFAULT_BLOCK_BYTES;
      end else if (csr_write) begin
         case (csr_index)
            bclru_pkg::CSR_BASE_LBA:    base_ff  <= csr_data;
            bclru_pkg::CSR_BLOCK_BYTES: bytes_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rvalid_in = 1'b0;
      rep_in    = rep_ff;
      hit_in    = hit_ff;
      inv_in    = inv_ff;
      vic_in    = vic_ff;
      vstamp_in = vstamp_ff;
      vslot_in  = vslot_ff;
      raddr     = cnt_ff[SB-1:0];
      we        = 1'b0;
      waddr     = rslot_ff;
      wdata     = rd_ff;
      ctl_in    = '0;
      case (state_ff)
         bclru_pkg::ST_WIPE: begin
            we    = 1'b1;
            waddr = cnt_ff[SB-1:0];
            wdata = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CB'(bclru_pkg::NUM_SLOTS - 1)) state_in = bclru_pkg::ST_IDLE;
         end
         bclru_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in = '0;
               hit_in = 1'b0;
               inv_in = 1'b0;
               rep_in = '0;
               vstamp_in = '1;
               if (req_command > bclru_pkg::CMD_DIRTY_LIST ||
                   (req_command == bclru_pkg::CMD_PARTIAL &&
                    req_byte_offset >= eff_bytes)) begin
                  state_in = bclru_pkg::ST_DONE;
               end else if (req_command <= bclru_pkg::CMD_PARTIAL) begin
                  state_in = bclru_pkg::ST_SCAN;
               end else begin
                  state_in = bclru_pkg::ST_SWEEP;
               end
            end
         end
         bclru_pkg::ST_SCAN: begin
            if (!scan_end && !hit_ff) begin
               cnt_in = cnt_ff + 1'b1;
               rvalid_in = 1'b1;
            end
            if (rvalid_ff && !hit_ff) begin
               if (rd_ff.valid && rd_ff.blk == blk_ff) begin
                  hit_in = 1'b1;
                  vic_in = rslot_ff;
                  vslot_in = rd_ff;
               end else if (!rd_ff.valid && !inv_ff) begin
                  inv_in = 1'b1;
                  vic_in = rslot_ff;
                  vslot_in = rd_ff;
               end else if (!inv_ff && (rd_ff.stamp < vstamp_ff || rslot_ff == '0)) begin
                  vstamp_in = rd_ff.stamp;
                  vic_in = rslot_ff;
                  vslot_in = rd_ff;
               end
            end
            if (hit_ff || (scan_end && !rvalid_ff)) begin
               state_in = bclru_pkg::ST_MISS;
            end
         end
         bclru_pkg::ST_MISS: begin
            if (hit_ff) begin
               state_in = bclru_pkg::ST_DONE;
            end else if (vslot_ff.valid && vslot_ff.dirty && !inv_ff) begin
               state_in = bclru_pkg::ST_WB;
            end else begin
               state_in = bclru_pkg::ST_FILL;
            end
         end
         bclru_pkg::ST_WB: begin
            ctl_in.strobe = 1'b1;
            ctl_in.kind   = bclru_pkg::KIND_WRITEBACK;
            ctl_in.slot   = vic_ff;
            ctl_in.blk    = vslot_ff.blk;
            ctl_in.lba_en = 1'b1;
            state_in = bclru_pkg::ST_FILL;
         end
         bclru_pkg::ST_FILL: begin
            ctl_in.strobe = 1'b1;
            ctl_in.kind   = bclru_pkg::KIND_FILL;
            ctl_in.slot   = vic_ff;
            ctl_in.blk    = blk_ff;
            ctl_in.lba_en = 1'b1;
            state_in = bclru_pkg::ST_DONE;
         end
         bclru_pkg::ST_DONE: begin
            ctl_in.strobe = 1'b1;
            ctl_in.last   = 1'b1;
            if (reject_ff) begin
               ctl_in.kind = bclru_pkg::KIND_REJECT;
            end else begin
               ctl_in.kind = bclru_pkg::KIND_DONE;
               if (cmd_ff <= bclru_pkg::CMD_PARTIAL) begin
                  ctl_in.slot = vic_ff;
                  ctl_in.blk  = blk_ff;
                  we    = 1'b1;
                  waddr = vic_ff;
                  wdata.valid = 1'b1;
                  wdata.blk   = blk_ff;
                  wdata.stamp = clock_ff + 32'd1;
                  wdata.dirty = (cmd_ff != bclru_pkg::CMD_READ) ||
                                (hit_ff && vslot_ff.dirty);
               end
               if (cmd_ff == bclru_pkg::CMD_PARTIAL) ctl_in.clip = clip_ff;
               if (cmd_ff == bclru_pkg::CMD_DIRTY_LIST) ctl_in.count = rep_ff;
            end
            state_in = bclru_pkg::ST_IDLE;
         end
         bclru_pkg::ST_SWEEP: begin
            if (!scan_end) begin
               rvalid_in = 1'b1;
               state_in = bclru_pkg::ST_SWEEP_OUT;
            end else begin
               state_in = bclru_pkg::ST_DONE;
            end
         end
         bclru_pkg::ST_SWEEP_OUT: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = bclru_pkg::ST_SWEEP;
            if (rd_ff.valid && rd_ff.dirty) begin
               ctl_in.slot = rslot_ff;
               ctl_in.blk  = rd_ff.blk;
               if (cmd_ff == bclru_pkg::CMD_DIRTY_LIST) begin
                  if (rep_ff < maxr_ff) begin
                     ctl_in.strobe = 1'b1;
                     ctl_in.kind   = bclru_pkg::KIND_REPORT;
                     rep_in = rep_ff + 5'd1;
                  end
               end else begin
                  ctl_in.strobe = 1'b1;
                  ctl_in.kind   = bclru_pkg::KIND_WRITEBACK;
                  ctl_in.lba_en = 1'b1;
               end
            end
            if (cmd_ff != bclru_pkg::CMD_DIRTY_LIST) begin
               we    = 1'b1;
               waddr = rslot_ff;
               wdata.dirty = 1'b0;
               if (cmd_ff == bclru_pkg::CMD_INVALIDATE) wdata.valid = 1'b0;
            end
         end
         default: state_in = bclru_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bclru_pkg::ST_WIPE;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
         clock_ff  <= '0;
         ctl_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
         ctl_ff    <= ctl_in;
         if (state_ff == bclru_pkg::ST_DONE && !reject_ff &&
             cmd_ff <= bclru_pkg::CMD_PARTIAL) begin
            clock_ff <= clock_ff + 32'd1;
         end
      end
   end

   assign off_len = {1'b0, req_byte_offset} + {1'b0, req_byte_length};

   always_ff @(posedge clock) begin
      rslot_ff  <= raddr;
      rep_ff    <= rep_in;
      hit_ff    <= hit_in;
      inv_ff    <= inv_in;
      vic_ff    <= vic_in;
      vstamp_ff <= vstamp_in;
      vslot_ff  <= vslot_in;
      if (state_ff == bclru_pkg::ST_IDLE && start) begin
         cmd_ff    <= bclru_pkg::cmd_type'(req_command);
         blk_ff    <= req_block_number;
         maxr_ff   <= req_max_reports;
         reject_ff <= req_command > bclru_pkg::CMD_DIRTY_LIST ||
                      (req_command == bclru_pkg::CMD_PARTIAL &&
                       req_byte_offset >= eff_bytes);
         clip_ff   <= (off_len > {1'b0, eff_bytes}) ? eff_bytes - req_byte_offset
                                                     : req_byte_length;
      end
   end

   assign lba_blk = ctl_in.blk;

   bclru_lba_unit u_lba (
      .clock    (clock),
      .base_lba (base_ff),
      .sectors  (sectors),
      .blk      (lba_blk),
      .lba      (rsp_device_lba_raw)
   );

   assign busy               = (state_ff != bclru_pkg::ST_IDLE);
   assign rsp_strobe         = ctl_ff.strobe;
   assign rsp_kind           = ctl_ff.kind;
   assign rsp_slot_index     = 4'(ctl_ff.slot);
   assign rsp_result_block   = ctl_ff.blk;
   assign rsp_device_lba     = ctl_ff.lba_en ? rsp_device_lba_raw : 32'd0;
   assign rsp_sector_count   = ctl_ff.lba_en ? sectors : 8'd0;
   assign rsp_clipped_length = ctl_ff.clip;
   assign rsp_report_count   = ctl_ff.count;
   assign rsp_last           = ctl_ff.last;

endmodule
`default_nettype wire

/* rtl/bclru_lba_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bclru_lba_unit
// Registered device address: base plus block times sectors per block.
// ----------------------------------------------------------------------------
module bclru_lba_unit (
   input  wire logic        clock,
   input  wire logic [31:0] base_lba,
   input  wire logic [7:0]  sectors,
   input  wire logic [31:0] blk,
   output logic      [31:0] lba
);

   logic [31:0] lba_ff;
   logic [39:0] prod;

   assign prod = blk * sectors;
   assign lba  = lba_ff;

   always_ff @(posedge clock) begin
      lba_ff <= base_lba + prod[31:0];
   end

endmodule
`default_nettype wire

/* sim/bclru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_checker
// Watches the request, result and register ports of the cache tag engine,
// keeps its own copy of slot tags, dirty bits and recency stamps, predicts
// the results of every accepted transaction and compares them in order.
// ----------------------------------------------------------------------------
module bclru_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_block_number,
   input  wire logic [15:0] req_byte_offset,
   input  wire logic [15:0] req_byte_length,
   input  wire logic [4:0]  req_max_reports,
   input  wire logic        rsp_strobe,
   input  wire logic [2:0]  rsp_kind,
   input  wire logic [3:0]  rsp_slot_index,
   input  wire logic [31:0] rsp_result_block,
   input  wire logic [31:0] rsp_device_lba,
   input  wire logic [7:0]  rsp_sector_count,
   input  wire logic [15:0] rsp_clipped_length,
   input  wire logic [4:0]  rsp_report_count,
   input  wire logic        rsp_last,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output int               errors,
   output int               pending
);

   typedef struct {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [31:0] blk;
      logic [31:0] lba;
      logic [7:0]  sectors;
      logic [15:0] clip;
      logic [4:0]  count;
      logic        last;
   } cache_rsp_type;

   cache_rsp_type expected_rsp[$];
   cache_rsp_type command_rsp[$];

   logic        line_valid [bclru_pkg::NUM_SLOTS];
   logic        line_dirty [bclru_pkg::NUM_SLOTS];
   logic [31:0] line_block [bclru_pkg::NUM_SLOTS];
   logic [31:0] line_stamp [bclru_pkg::NUM_SLOTS];
   logic [31:0] recency_clock;
   logic [31:0] base_lba;
   logic [15:0] block_size;

   function automatic logic [16:0] active_bytes();
      return (block_size == 16'd0) ? {1'b0, bclru_pkg::DEFAULT_BLOCK_BYTES}
                                   : {1'b0, block_size};
   endfunction

   function automatic logic [7:0] sectors_per_block();
      return 8'(active_bytes() / 512);
   endfunction

   function automatic logic [31:0] sector_of(logic [31:0] blk);
      logic [63:0] full;
      full = 64'(base_lba) + 64'(blk) * 64'(sectors_per_block());
      return full[31:0];
   endfunction

   task automatic add_rsp(bclru_pkg::kind_type kind, int slot, logic [31:0] blk,
                          logic [31:0] lba, logic [7:0] sc, logic [15:0] clip,
                          logic [4:0] cnt);
      cache_rsp_type r;
      r.kind = kind;
      r.slot = 4'(slot);
      r.blk = blk;
      r.lba = lba;
      r.sectors = sc;
      r.clip = clip;
      r.count = cnt;
      r.last = 1'b0;
      command_rsp.push_back(r);
   endtask

   task automatic write_back(int i);
      add_rsp(bclru_pkg::KIND_WRITEBACK, i, line_block[i], sector_of(line_block[i]),
              sectors_per_block(), 16'd0, 5'd0);
   endtask

   task automatic find_slot(logic [31:0] blk, output int slot);
      int victim;
      victim = -1;
      for (int i = 0; i < bclru_pkg::NUM_SLOTS; i++) begin
         if (line_valid[i] && line_block[i] == blk) begin
            recency_clock = recency_clock + 32'd1;
            line_stamp[i] = recency_clock;
            slot = i;
            return;
         end
      end
      for (int i = 0; i < bclru_pkg::NUM_SLOTS; i++) begin
         if (!line_valid[i]) begin
            victim = i;
            break;
         end
      end
      if (victim < 0) begin
         victim = 0;
         for (int i = 1; i < bclru_pkg::NUM_SLOTS; i++)
            if (line_stamp[i] < line_stamp[victim]) victim = i;
         if (line_dirty[victim]) write_back(victim);
      end
      add_rsp(bclru_pkg::KIND_FILL, victim, blk, sector_of(blk), sectors_per_block(),
              16'd0, 5'd0);
      line_block[victim] = blk;
      line_valid[victim] = 1'b1;
      line_dirty[victim] = 1'b0;
      recency_clock = recency_clock + 32'd1;
      line_stamp[victim] = recency_clock;
      slot = victim;
   endtask

   task automatic flush_lines();
      for (int i = 0; i < bclru_pkg::NUM_SLOTS; i++) begin
         if (line_valid[i] && line_dirty[i]) begin
            write_back(i);
            line_dirty[i] = 1'b0;
         end
      end
   endtask

   task automatic predict_command(logic [2:0] cmd, logic [31:0] blk, logic [15:0] offset,
                                  logic [15:0] length, logic [4:0] limit);
      int slot;
      logic [4:0] found;
      logic [16:0] bytes;
      logic [16:0] clip;
      cache_rsp_type r;
      found = 5'd0;
      bytes = active_bytes();
      command_rsp.delete();
      case (cmd)
         bclru_pkg::CMD_READ, bclru_pkg::CMD_WRITE: begin
            find_slot(blk, slot);
            if (cmd == bclru_pkg::CMD_WRITE) line_dirty[slot] = 1'b1;
            add_rsp(bclru_pkg::KIND_DONE, slot, blk, 32'd0, 8'd0, 16'd0, 5'd0);
         end
         bclru_pkg::CMD_PARTIAL: begin
            if ({1'b0, offset} >= bytes) begin
               add_rsp(bclru_pkg::KIND_REJECT, 0, 32'd0, 32'd0, 8'd0, 16'd0, 5'd0);
            end else begin
               clip = {1'b0, length};
               if ({1'b0, offset} + {1'b0, length} > bytes) clip = bytes - {1'b0, offset};
               find_slot(blk, slot);
               line_dirty[slot] = 1'b1;
               add_rsp(bclru_pkg::KIND_DONE, slot, blk, 32'd0, 8'd0, clip[15:0], 5'd0);
            end
         end
         bclru_pkg::CMD_FLUSH: begin
            flush_lines();
            add_rsp(bclru_pkg::KIND_DONE, 0, 32'd0, 32'd0, 8'd0, 16'd0, 5'd0);
         end
         bclru_pkg::CMD_INVALIDATE: begin
            flush_lines();
            for (int i = 0; i < bclru_pkg::NUM_SLOTS; i++) line_valid[i] = 1'b0;
            add_rsp(bclru_pkg::KIND_DONE, 0, 32'd0, 32'd0, 8'd0, 16'd0, 5'd0);
         end
         bclru_pkg::CMD_DIRTY_LIST: begin
            for (int i = 0; i < bclru_pkg::NUM_SLOTS && found < limit; i++) begin
               if (line_valid[i] && line_dirty[i]) begin
                  add_rsp(bclru_pkg::KIND_REPORT, i, line_block[i], 32'd0, 8'd0, 16'd0,
                          5'd0);
                  found = found + 5'd1;
               end
            end
            add_rsp(bclru_pkg::KIND_DONE, 0, 32'd0, 32'd0, 8'd0, 16'd0, found);
         end
         default: add_rsp(bclru_pkg::KIND_REJECT, 0, 32'd0, 32'd0, 8'd0, 16'd0, 5'd0);
      endcase
      r = command_rsp.pop_back();
      r.last = 1'b1;
      command_rsp.push_back(r);
      foreach (command_rsp[i]) expected_rsp.push_back(command_rsp[i]);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cache_rsp_type e;
      if (reset) begin
         for (int i = 0; i < bclru_pkg::NUM_SLOTS; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_block[i] = 32'd0;
            line_stamp[i] = 32'd0;
         end
         recency_clock = 32'd0;
         base_lba = 32'd0;
         block_size = bclru_pkg::DEFAULT_BLOCK_BYTES;
         expected_rsp.delete();
         errors = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == bclru_pkg::CSR_BASE_LBA) base_lba = csr_data;
            else block_size = csr_data[15:0];
         end
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0h block %0h",
                        $time, rsp_kind, rsp_result_block);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("kind", 32'(e.kind), 32'(rsp_kind));
               check_field("slot_index", 32'(e.slot), 32'(rsp_slot_index));
               check_field("result_block", e.blk, rsp_result_block);
               check_field("device_lba", e.lba, rsp_device_lba);
               check_field("sector_count", 32'(e.sectors), 32'(rsp_sector_count));
               check_field("clipped_length", 32'(e.clip), 32'(rsp_clipped_length));
               check_field("report_count", 32'(e.count), 32'(rsp_report_count));
               check_field("last", 32'(e.last), 32'(rsp_last));
            end
         end
         if (start && !busy)
            predict_command(req_command, req_block_number, req_byte_offset,
                            req_byte_length, req_max_reports);
      end
      pending = expected_rsp.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random cache commands through several partition base
// and block size settings, with bursty request timing, and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [2:0] CMD_UNUSED_A = 3'd6;
   localparam logic [2:0] CMD_UNUSED_B = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = 3'd0;
   logic [31:0] req_block_number = 32'd0;
   logic [15:0] req_byte_offset = 16'd0;
   logic [15:0] req_byte_length = 16'd0;
   logic [4:0]  req_max_reports = 5'd0;
   logic        rsp_strobe;
   logic [2:0]  rsp_kind;
   logic [3:0]  rsp_slot_index;
   logic [31:0] rsp_result_block;
   logic [31:0] rsp_device_lba;
   logic [7:0]  rsp_sector_count;
   logic [15:0] rsp_clipped_length;
   logic [4:0]  rsp_report_count;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = 1'b0;
   logic [31:0] csr_data = 32'd0;
   int          errors;
   int          pending;
   int          burst_left = 0;
   logic [16:0] cur_bytes = 17'd1024;

   always #5 clock = ~clock;

   block_cache_lru_controller_core uut (.*);

   bclru_checker u_checker (.*);

   task automatic send_command(logic [2:0] cmd, logic [31:0] blk, logic [15:0] offset,
                               logic [15:0] length, logic [4:0] limit);
      req_command <= cmd;
      req_block_number <= blk;
      req_byte_offset <= offset;
      req_byte_length <= length;
      req_max_reports <= limit;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 6);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   endtask

   task automatic write_register(bclru_pkg::csr_index_type idx, logic [31:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == bclru_pkg::CSR_BLOCK_BYTES)
         cur_bytes = (value[15:0] == 16'd0) ? 17'd1024 : {1'b0, value[15:0]};
   endtask

   task automatic random_command();
      logic [31:0] blk;
      logic [15:0] offset;
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) blk = $urandom();
      else blk = $urandom_range(0, 23);
      if ($urandom_range(0, 3) == 0) offset = 16'($urandom());
      else offset = 16'($urandom_range(0, int'(cur_bytes) - 1));
      if (pick < 30)
         send_command(bclru_pkg::CMD_READ, blk, 16'($urandom()), 16'($urandom()),
                      5'($urandom()));
      else if (pick < 55)
         send_command(bclru_pkg::CMD_WRITE, blk, 16'($urandom()), 16'($urandom()),
                      5'($urandom()));
      else if (pick < 80)
         send_command(bclru_pkg::CMD_PARTIAL, blk, offset, 16'($urandom()),
                      5'($urandom()));
      else if (pick < 85) send_command(bclru_pkg::CMD_FLUSH, blk, 16'd0, 16'd0, 5'd0);
      else if (pick < 89)
         send_command(bclru_pkg::CMD_INVALIDATE, blk, 16'd0, 16'd0, 5'd0);
      else if (pick < 97)
         send_command(bclru_pkg::CMD_DIRTY_LIST, blk, 16'd0, 16'd0,
                      5'($urandom_range(0, 16)));
      else send_command($urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B, blk,
                        16'd0, 16'd0, 5'd0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(bclru_pkg::CMD_READ, 32'd0, 16'd0, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_READ, 32'd0, 16'd0, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 5'h1F);
      send_command(bclru_pkg::CMD_PARTIAL, 32'd5, 16'd0, 16'hFFFF, 5'd0);
      send_command(bclru_pkg::CMD_PARTIAL, 32'd6, 16'd1023, 16'd1, 5'd0);
      send_command(bclru_pkg::CMD_PARTIAL, 32'd7, 16'd1024, 16'd1, 5'd0);
      send_command(bclru_pkg::CMD_PARTIAL, 32'd7, 16'hFFFF, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_DIRTY_LIST, 32'd0, 16'd0, 16'd0, 5'd16);
      send_command(bclru_pkg::CMD_DIRTY_LIST, 32'd0, 16'd0, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_FLUSH, 32'd0, 16'd0, 16'd0, 5'd0);
      send_command(CMD_UNUSED_A, 32'd0, 16'd0, 16'd0, 5'd0);
      send_command(CMD_UNUSED_B, 32'd0, 16'd0, 16'd0, 5'd0);
      for (int i = 0; i < 12; i++)
         send_command(bclru_pkg::CMD_WRITE, 32'd100 + i, 16'd0, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_READ, 32'd200, 16'd0, 16'd0, 5'd0);
      send_command(bclru_pkg::CMD_INVALIDATE, 32'd0, 16'd0, 16'd0, 5'd0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_register(bclru_pkg::CSR_BASE_LBA, 32'hFFFF_FFFF);
               write_register(bclru_pkg::CSR_BLOCK_BYTES, 32'hFFFF_0000);
            end
            2: begin
               write_register(bclru_pkg::CSR_BASE_LBA, $urandom());
               write_register(bclru_pkg::CSR_BLOCK_BYTES, 32'h0000_FFFF);
            end
            3: write_register(bclru_pkg::CSR_BLOCK_BYTES, 32'd511);
            4: begin
               write_register(bclru_pkg::CSR_BASE_LBA, 32'd0);
               write_register(bclru_pkg::CSR_BLOCK_BYTES, 32'd512);
            end
            default: begin
               write_register(bclru_pkg::CSR_BASE_LBA, $urandom());
               write_register(bclru_pkg::CSR_BLOCK_BYTES, 32'd4096);
            end
         endcase
         for (int n = 0; n < 51; n++) random_command();
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("block_cache_lru_controller_core verification clean");
      else
         $display("block_cache_lru_controller_core verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("block_cache_lru_controller_core verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/bclru_pkg.sv
rtl/bclru_lba_unit.sv
rtl/block_cache_lru_controller_core.sv
sim/bclru_checker.sv
sim/tb.sv
